### sv/brr_pkg.sv
// shared types and constants for the bit-reversal reorder block
package brr_pkg;

	// width of one sample part on the ports
	localparam int SAMPLE_W = 32;

	// frame length register
	localparam int LOG_SIZE_W = 4;
	localparam logic [LOG_SIZE_W-1:0] LOG_SIZE_RST = 4'd10;
	localparam int MIN_LOG_SIZE = 3;

	// per-transaction control from the sequencer to the datapath
	typedef struct packed {
		logic wr_en;
		logic rd_en;
		logic frame_end;
	} brr_ctl_t;

endpackage

### sv/brr_store.sv
// ping-pong sample memory with one write port and one registered read port
module brr_store import brr_pkg::*; #(
	parameter int ADDR_W = 11,
	parameter int DATA_W = 64
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data_s1
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

endmodule

### sv/brr_seq.sv
// frame position, bank and bit-reversed address generation
module brr_seq import brr_pkg::*; #(
	parameter int MAX_LOG_SIZE = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic                  cfg_we,
	input  logic [LOG_SIZE_W-1:0] cfg_wdata,
	output brr_ctl_t              ctl,
	output logic [MAX_LOG_SIZE:0] wr_addr,
	output logic [MAX_LOG_SIZE:0] rd_addr
);

	localparam int POS_W = MAX_LOG_SIZE;
	localparam int CNT_W = $clog2(MAX_LOG_SIZE + 1);

	logic [LOG_SIZE_W-1:0] log_size_q;
	logic [POS_W-1:0]      position_q;
	logic                  bank_q;
	logic                  primed_q;

	logic [CNT_W-1:0] bits;
	logic [CNT_W-1:0] shift;
	logic [POS_W-1:0] last;
	logic [POS_W-1:0] pos;
	logic [POS_W-1:0] rev_full;
	logic [POS_W-1:0] rev;
	logic             is_last;

	// clamp the frame length to the supported range
	always_comb begin
		if (int'(log_size_q) < MIN_LOG_SIZE) begin
			bits = CNT_W'(MIN_LOG_SIZE);
		end else if (int'(log_size_q) > MAX_LOG_SIZE) begin
			bits = CNT_W'(MAX_LOG_SIZE);
		end else begin
			bits = CNT_W'(log_size_q);
		end
		shift = CNT_W'(MAX_LOG_SIZE) - bits;
	end

	// index within the frame and its bit reversal over the frame length
	always_comb begin
		last    = {POS_W{1'b1}} >> shift;
		pos     = position_q & last;
		is_last = (pos == last);
		for (int k = 0; k < POS_W; k++) begin
			rev_full[k] = pos[POS_W-1-k];
		end
		rev = rev_full >> shift;
	end

	// write the current half, read the previous frame from the other half
	assign wr_addr = {bank_q, pos};
	assign rd_addr = {~bank_q, rev};

	assign ctl.wr_en     = accept;
	assign ctl.rd_en     = accept && primed_q;
	assign ctl.frame_end = is_last;

	// frame bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log_size_q <= LOG_SIZE_RST;
			position_q <= '0;
			bank_q     <= 1'b0;
			primed_q   <= 1'b0;
		end else if (cfg_we) begin
			log_size_q <= cfg_wdata;
			position_q <= '0;
			primed_q   <= 1'b0;
		end else if (accept) begin
			if (is_last) begin
				position_q <= '0;
				bank_q     <= ~bank_q;
				primed_q   <= 1'b1;
			end else begin
				position_q <= pos + POS_W'(1);
			end
		end
	end

endmodule

### sv/bit_reversal_reorder.sv
// top level of the bit-reversal reorder block
//
// Reorders frames of 2^log_size complex samples into bit-reversed order.
// Input transactions (sample_valid/sample_ready) carry one complex sample;
// output transactions (result_valid/result_ready) carry one sample of the
// previous frame taken at the bit-reversed index, with frame_end on the
// last sample of each frame. One frame of delay: the first frame after
// reset or after a log_size write gives no output.
// Throughput is one sample per cycle unless sample_ready drops: each
// transaction costs one memory write and one memory read on separate
// ports of the ping-pong store. A result passes through the memory read
// register, which loads at the accepting edge, and then the output
// register, which loads once it is free or is being emptied.
// The memory read register and the output register form a two-entry
// buffer, so input is still taken while one result waits; sample_ready
// drops only when both hold results and result_ready is low.
// Reset clears position, bank and the frame flag and sets log_size to 10;
// the store itself is not cleared and needs no clearing pass.
// log_size must be written through log_size_we/log_size_wdata while idle
// (unenforced); values outside 3..MAX_LOG_SIZE act as the nearest limit.
module bit_reversal_reorder import brr_pkg::*; #(
	parameter int MAX_LOG_SIZE = 10,
	parameter int PART_WIDTH   = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  log_size_we,
	input  logic [LOG_SIZE_W-1:0] log_size_wdata,
	input  logic                  sample_valid,
	output logic                  sample_ready,
	input  logic [SAMPLE_W-1:0]   sample_real,
	input  logic [SAMPLE_W-1:0]   sample_imag,
	output logic                  result_valid,
	input  logic                  result_ready,
	output logic [SAMPLE_W-1:0]   out_real,
	output logic [SAMPLE_W-1:0]   out_imag,
	output logic                  frame_end
);

	localparam int ADDR_W = MAX_LOG_SIZE + 1;
	localparam int DATA_W = 2 * PART_WIDTH;

	brr_ctl_t          ctl;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr;
	logic [DATA_W-1:0] rd_data_s1;
	logic              accept;
	logic              valid_s1;
	logic              frame_end_s1;
	logic              move;

	logic                  result_valid_q;
	logic [PART_WIDTH-1:0] out_real_q;
	logic [PART_WIDTH-1:0] out_imag_q;
	logic                  frame_end_q;

	// handshake: read stage frees when it moves into the output register
	assign move         = valid_s1 && (!result_valid_q || result_ready);
	assign sample_ready = !valid_s1 || !result_valid_q || result_ready;
	assign accept       = sample_valid && sample_ready;

	brr_seq #(
		.MAX_LOG_SIZE(MAX_LOG_SIZE)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.cfg_we   (log_size_we),
		.cfg_wdata(log_size_wdata),
		.ctl      (ctl),
		.wr_addr  (wr_addr),
		.rd_addr  (rd_addr)
	);

	brr_store #(
		.ADDR_W(ADDR_W),
		.DATA_W(DATA_W)
	) u_store (
		.clk       (clk),
		.wr_en     (ctl.wr_en),
		.wr_addr   (wr_addr),
		.wr_data   ({sample_imag[PART_WIDTH-1:0], sample_real[PART_WIDTH-1:0]}),
		.rd_en     (ctl.rd_en),
		.rd_addr   (rd_addr),
		.rd_data_s1(rd_data_s1)
	);

	// read stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ctl.rd_en) begin
			valid_s1 <= 1'b1;
		end else if (move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			frame_end_s1 <= ctl.frame_end;
		end
	end

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (move) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (move) begin
			out_real_q  <= rd_data_s1[PART_WIDTH-1:0];
			out_imag_q  <= rd_data_s1[DATA_W-1:PART_WIDTH];
			frame_end_q <= frame_end_s1;
		end
	end

	assign result_valid = result_valid_q;
	assign out_real     = SAMPLE_W'(out_real_q);
	assign out_imag     = SAMPLE_W'(out_imag_q);
	assign frame_end    = frame_end_q;

endmodule

### tb/testbench.sv
// testbench for the bit-reversal reorder block: directed frames, random frames, own reorder model
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import brr_pkg::*;

	localparam int MAX_LOG       = 10;
	localparam int STORE_DEPTH   = 1 << MAX_LOG;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int DIRECTED_ROWS = 24;
	localparam int PHASES        = 8;
	localparam int SHOWN_ERRORS  = 10;

	// one output sample as it should leave the block
	typedef struct packed {
		logic [SAMPLE_W-1:0] re;
		logic [SAMPLE_W-1:0] im;
		logic                last;
	} reordered_t;

	// one row of the directed table
	typedef struct {
		logic [SAMPLE_W-1:0] re;
		logic [SAMPLE_W-1:0] im;
		bit                  typed;
		bit                  has;
		reordered_t          want;
	} step_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  log_size_we = 1'b0;
	logic [LOG_SIZE_W-1:0] log_size_wdata = '0;
	logic                  sample_valid = 1'b0;
	logic                  sample_ready;
	logic [SAMPLE_W-1:0]   sample_real = '0;
	logic [SAMPLE_W-1:0]   sample_imag = '0;
	logic                  result_valid;
	logic                  result_ready = 1'b0;
	logic [SAMPLE_W-1:0]   out_real;
	logic [SAMPLE_W-1:0]   out_imag;
	logic                  frame_end;

	// reorder model state
	logic [2*SAMPLE_W-1:0] frame_store [2][STORE_DEPTH];
	logic [MAX_LOG-1:0]    write_pos = '0;
	bit                    write_bank = 1'b0;
	bit                    frame_ready = 1'b0;
	logic [LOG_SIZE_W-1:0] frame_log_reg = LOG_SIZE_RST;

	reordered_t reordered_q[$];
	reordered_t oldest;
	step_t      steps [DIRECTED_ROWS];
	int         mismatches = 0;
	int         cycles = 0;
	bit         steady = 1'b0;

	bit_reversal_reorder #(
		.MAX_LOG_SIZE(MAX_LOG),
		.PART_WIDTH(SAMPLE_W)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.log_size_we(log_size_we),
		.log_size_wdata(log_size_wdata),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample_real(sample_real),
		.sample_imag(sample_imag),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.out_real(out_real),
		.out_imag(out_imag),
		.frame_end(frame_end)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// frame length in address bits, clamped to the supported range
	function automatic int frame_bits();
		if (frame_log_reg < MIN_LOG_SIZE)
			return MIN_LOG_SIZE;
		if (frame_log_reg > MAX_LOG)
			return MAX_LOG;
		return frame_log_reg;
	endfunction

	// store one sample, return the previous-frame sample at the bit-reversed position
	function automatic bit reorder_sample(input logic [SAMPLE_W-1:0] re, im,
			output reordered_t r);
		int                 bits;
		logic [MAX_LOG-1:0] last_pos;
		logic [MAX_LOG-1:0] pos;
		logic [MAX_LOG-1:0] rev;
		logic [2*SAMPLE_W-1:0] word;
		bit                 has;
		bits = frame_bits();
		last_pos = MAX_LOG'((1 << bits) - 1);
		pos = write_pos & last_pos;
		rev = '0;
		for (int k = 0; k < bits; k++)
			rev = {rev[MAX_LOG-2:0], pos[k]};
		has = frame_ready;
		r = '0;
		if (frame_ready) begin
			word = frame_store[write_bank ^ 1'b1][rev];
			r.re = word[SAMPLE_W-1:0];
			r.im = word[2*SAMPLE_W-1:SAMPLE_W];
			r.last = (pos == last_pos);
		end
		frame_store[write_bank][pos] = {im, re};
		if (pos == last_pos) begin
			write_pos = '0;
			write_bank = write_bank ^ 1'b1;
			frame_ready = 1'b1;
		end else begin
			write_pos = pos + 1'b1;
		end
		return has;
	endfunction

	// random sample part, with a share of corner words
	function automatic logic [SAMPLE_W-1:0] random_part();
		case ($urandom_range(15))
			0: return '0;
			1: return '1;
			2: return 32'h8000_0000;
			3: return 32'h7FFF_FFFF;
			default: return $urandom();
		endcase
	endfunction

	// one input transaction, with an optional gap before it
	task automatic send_sample(input logic [SAMPLE_W-1:0] re, im, input bit typed,
			input bit typed_has, input reordered_t typed_want);
		reordered_t got;
		bit         has;
		if (!steady && $urandom_range(99) < 33) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		sample_valid <= 1'b1;
		sample_real <= re;
		sample_imag <= im;
		do
			@(posedge clk);
		while (!sample_ready);
		has = reorder_sample(re, im, got);
		if (typed) begin
			has = typed_has;
			got = typed_want;
		end
		if (has)
			reordered_q.push_back(got);
		@(negedge clk);
	endtask

	// stop sending and wait until every pending sample has come out
	task automatic settle();
		sample_valid <= 1'b0;
		while (reordered_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// frame length write, drops the frame in progress
	task automatic write_log_size(input logic [LOG_SIZE_W-1:0] value);
		log_size_we <= 1'b1;
		log_size_wdata <= value;
		frame_log_reg = value;
		write_pos = '0;
		frame_ready = 1'b0;
		@(negedge clk);
		log_size_we <= 1'b0;
	endtask

	// receiver side: random back-pressure except in the steady stretch
	always @(negedge clk) begin
		result_ready <= steady || ($urandom_range(99) >= 33);
	end

	// output transaction check against the oldest pending sample
	always @(posedge clk) begin
		if (arst_n && result_valid === 1'b1 && result_ready) begin
			if (reordered_q.size() == 0) begin
				mismatches++;
				if (mismatches <= SHOWN_ERRORS)
					$display("unexpected output: real %h imag %h end %b",
						out_real, out_imag, frame_end);
			end else begin
				oldest = reordered_q.pop_front();
				if (out_real !== oldest.re || out_imag !== oldest.im
						|| frame_end !== oldest.last) begin
					mismatches++;
					if (mismatches <= SHOWN_ERRORS)
						$display("output mismatch: want real %h imag %h end %b, got real %h imag %h end %b",
							oldest.re, oldest.im, oldest.last, out_real, out_imag, frame_end);
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// stimulus
	initial begin
		logic [LOG_SIZE_W-1:0] phase_log [PHASES];
		int                    phase_len [PHASES];

		// out-of-range values act as the nearest limit; lengths end mid-frame on purpose
		phase_log = '{4'd0, 4'd4, 4'd15, 4'd5, 4'd6, 4'd2, 4'd3, 4'd1};
		phase_len = '{59, 93, 1056, 101, 103, 41, 61, 33};

		// frame 0 loads with no output
		steps[0]  = '{32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0, '0};
		steps[1]  = '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0, '0};
		steps[2]  = '{32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0, '0};
		steps[3]  = '{32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b0, '0};
		steps[4]  = '{32'hAAAA_AAAA, 32'h5555_5555, 1'b1, 1'b0, '0};
		steps[5]  = '{32'h5555_5555, 32'hAAAA_AAAA, 1'b1, 1'b0, '0};
		steps[6]  = '{32'h0000_0001, 32'hFFFF_FFFE, 1'b1, 1'b0, '0};
		steps[7]  = '{32'hFFFF_FFFE, 32'h0000_0001, 1'b1, 1'b0, '0};
		// frame 1 returns frame 0 in order 0 4 2 6 1 5 3 7
		steps[8]  = '{32'h0123_4567, 32'h89AB_CDEF, 1'b1, 1'b1,
			'{32'h0000_0000, 32'hFFFF_FFFF, 1'b0}};
		steps[9]  = '{32'hFEDC_BA98, 32'h7654_3210, 1'b1, 1'b1,
			'{32'hAAAA_AAAA, 32'h5555_5555, 1'b0}};
		steps[10] = '{32'h0F0F_0F0F, 32'hF0F0_F0F0, 1'b1, 1'b1,
			'{32'h8000_0000, 32'h7FFF_FFFF, 1'b0}};
		steps[11] = '{32'h3333_3333, 32'hCCCC_CCCC, 1'b1, 1'b1,
			'{32'h0000_0001, 32'hFFFF_FFFE, 1'b0}};
		steps[12] = '{32'h1357_9BDF, 32'h2468_ACE0, 1'b1, 1'b1,
			'{32'hFFFF_FFFF, 32'h0000_0000, 1'b0}};
		steps[13] = '{32'h0000_FFFF, 32'hFFFF_0000, 1'b1, 1'b1,
			'{32'h5555_5555, 32'hAAAA_AAAA, 1'b0}};
		steps[14] = '{32'h00FF_00FF, 32'hFF00_FF00, 1'b1, 1'b1,
			'{32'h7FFF_FFFF, 32'h8000_0000, 1'b0}};
		steps[15] = '{32'h8000_0001, 32'h7FFF_FFFE, 1'b1, 1'b1,
			'{32'hFFFF_FFFE, 32'h0000_0001, 1'b1}};
		// frame 2 returns frame 1, left to the model
		steps[16] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, '0};
		steps[17] = '{32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, '0};
		steps[18] = '{32'hC3C3_C3C3, 32'h3C3C_3C3C, 1'b0, 1'b0, '0};
		steps[19] = '{32'h6969_6969, 32'h9696_9696, 1'b0, 1'b0, '0};
		steps[20] = '{32'h0000_0002, 32'h4000_0000, 1'b0, 1'b0, '0};
		steps[21] = '{32'hDB6D_B6DB, 32'h2492_4924, 1'b0, 1'b0, '0};
		steps[22] = '{32'h1111_1111, 32'hEEEE_EEEE, 1'b0, 1'b0, '0};
		steps[23] = '{32'h7777_7777, 32'h8888_8888, 1'b0, 1'b0, '0};

		// reset
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// directed frames at the smallest length
		write_log_size(4'd3);
		for (int i = 0; i < DIRECTED_ROWS; i++)
			send_sample(steps[i].re, steps[i].im, steps[i].typed, steps[i].has, steps[i].want);

		// random frames over several lengths
		for (int p = 0; p < PHASES; p++) begin
			settle();
			write_log_size(phase_log[p]);
			for (int n = 0; n < phase_len[p]; n++) begin
				steady = (p == 2 && n >= 300 && n < 700);
				// hold the sender until the output side has caught up
				if (p % 2 == 1 && n == phase_len[p] / 2)
					settle();
				send_sample(random_part(), random_part(), 1'b0, 1'b0, '0);
			end
		end
		steady = 1'b0;

		// drain and report
		settle();
		repeat (10) @(negedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
